// ===== design/lsbse_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types and constants for the two-bit LSB embed / extract block.
// ----------------------------------------------------------------------------
package lsbse_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE        = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD_LEN = 2'd1;
    localparam logic [1:0] CFG_IMAGE_LEN   = 2'd2;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // stream layout positions
    localparam logic [31:0] HDR_LAST_POS  = 32'd15;
    localparam logic [31:0] DATA_START    = 32'd64;
    localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       length_error;
        logic       payload_last;
        logic       payload_valid;
        logic [7:0] payload_byte_out;
        logic [7:0] image_byte_out;
    } lsbse_result_t;

endpackage

// ===== design/lsb_stego_embed_extract.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract
// Two-bit LSB steganography on an image byte stream, embed or extract.
// ----------------------------------------------------------------------------
// One image byte per item, one result per item. The whole per-byte work
// (bit-field merge or extract, position count, group compares) sits between
// the state registers and a single output register; the throughput is one
// item per clock whenever the output side takes results. In embed mode bytes
// 0-15 carry the 32-bit payload_length two bits at a time, bytes 16-63 pass
// through and from byte 64 each group of four bytes carries one payload byte
// (payload_byte is sampled on the first byte of a group). In extract mode the
// length is rebuilt from bytes 0-15, checked against image_length/4 on byte 15,
// and payload bytes are output on the fourth byte of each group.
// Configuration is to be written by the user only while no item is in flight;
// the block does not enforce this. tuser on the input marks image byte 0.
module lsb_stego_embed_extract (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // image_byte, payload_byte
    input  logic        s_axis_tuser,   // first_of_image

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // image_byte_out, payload_byte_out
    output logic        m_axis_tlast,   // payload_last
    output logic [1:0]  m_axis_tuser    // payload_valid, length_error
);
    import lsbse_pkg::*;

    logic        mode_reg;
    logic [31:0] payload_len_reg;
    logic [31:0] image_len_reg;

    logic [31:0] pos_reg,  pos_next;
    logic [31:0] hdr_reg,  hdr_next;
    logic [7:0]  asm_reg,  asm_next;
    logic [7:0]  held_reg, held_next;
    logic        err_reg,  err_next;

    logic          out_valid_reg;
    lsbse_result_t out_reg, out_next;

    logic        accept;
    logic [7:0]  img;
    logic [7:0]  pay;
    logic [1:0]  pair;
    logic [31:0] pos;
    logic [31:0] hdr_cur;
    logic        err_cur;
    logic [31:0] rel;
    logic [29:0] grp;
    logic [1:0]  off;
    logic [31:0] start;
    logic [31:0] len;
    logic        used;
    logic        last_grp;
    logic [7:0]  held_cur;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign img  = s_axis_tdata[7:0];
    assign pay  = s_axis_tdata[15:8];
    assign pair = img[1:0];

    // restart on the marked byte; header and error clear on byte 0
    assign pos     = s_axis_tuser ? '0 : pos_reg;
    assign hdr_cur = (pos == '0) ? '0 : hdr_reg;
    assign err_cur = (pos == '0) ? 1'b0 : err_reg;

    // group bookkeeping; start is the group base, a multiple of four
    assign rel      = pos - DATA_START;
    assign grp      = rel[31:2];
    assign off      = rel[1:0];
    assign start    = {pos[31:2], 2'b00};
    assign len      = (mode_reg == MODE_EMBED) ? payload_len_reg : hdr_reg;
    assign used     = ({2'b00, grp} < len) && (start < image_len_reg);
    assign last_grp = ({3'b000, grp} + 33'd1 == {1'b0, len})
                   || ({2'b00, start} + 34'd4 >= {2'b00, image_len_reg});
    assign held_cur = (off == 2'd0) ? pay : held_reg;

    always_comb
    begin
        hdr_next  = hdr_cur;
        err_next  = err_cur;
        asm_next  = asm_reg;
        held_next = held_reg;
        out_next  = '0;
        out_next.image_byte_out = img;

        if (pos[31:4] == '0) begin
            if (mode_reg == MODE_EMBED) begin
                out_next.image_byte_out =
                    {img[7:2], payload_len_reg[{pos[3:0], 1'b0} +: 2]};
            end else begin
                hdr_next = hdr_cur | (32'(pair) << {pos[3:0], 1'b0});
                if (pos == HDR_LAST_POS)
                    err_next = hdr_next > {2'b00, image_len_reg[31:2]};
            end
        end else if (pos >= DATA_START && used) begin
            if (mode_reg == MODE_EMBED) begin
                held_next = held_cur;
                out_next.image_byte_out = {img[7:2], held_cur[{off, 1'b0} +: 2]};
            end else if (!err_cur) begin
                if (off == 2'd0)
                    asm_next = {6'd0, pair};
                else
                    asm_next = asm_reg | (8'(pair) << {off, 1'b0});
                if (off == 2'd3) begin
                    out_next.payload_byte_out = asm_next;
                    out_next.payload_valid    = 1'b1;
                    out_next.payload_last     = last_grp;
                end
            end
        end

        out_next.length_error = (mode_reg == MODE_EXTRACT) ? err_next : 1'b0;
        pos_next = (pos == POS_MAX) ? pos : pos + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg        <= MODE_EMBED;
            payload_len_reg <= '0;
            image_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:        mode_reg        <= cfg_data[0];
                CFG_PAYLOAD_LEN: payload_len_reg <= cfg_data;
                CFG_IMAGE_LEN:   image_len_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            asm_reg  <= '0;
            held_reg <= '0;
            err_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            asm_reg  <= asm_next;
            held_reg <= held_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.payload_byte_out, out_reg.image_byte_out};
    assign m_axis_tlast  = out_reg.payload_last;
    assign m_axis_tuser  = {out_reg.length_error, out_reg.payload_valid};

`ifndef SYNTHESIS
    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("payload_last without payload_valid");

    a_idle_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:8] == 8'd0)
        else $error("payload byte non-zero without payload_valid");

    a_pos_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_axis_tuser && pos_reg != POS_MAX |=> pos_reg == $past(pos_reg) + 32'd1)
        else $error("byte position did not advance");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tuser |=> pos_reg == 32'd1 && !err_reg)
        else $error("restart did not reset position and error");
`endif

endmodule
